@@ rtl/odsc_pkg.sv @@
// ----------------------------------------------------------------------------
// odsc_pkg
// Shared constants, types and helpers of the online distinct substring counter.
// ----------------------------------------------------------------------------
package odsc_pkg;

    localparam int MAX_LEN  = 4096;
    localparam int ALPHABET = 26;
    localparam int NSTATE   = 2 * MAX_LEN;

    localparam int SW     = $clog2(NSTATE);          // state index
    localparam int LW     = $clog2(MAX_LEN + 1);     // length and path count
    localparam int NFW    = SW + 1;                  // next free state
    localparam int TDEPTH = NSTATE * ALPHABET;       // transition entries
    localparam int TAW    = $clog2(TDEPTH);
    localparam int EW     = 8;                       // epoch tag
    localparam int KW     = $clog2(ALPHABET + 1);
    localparam int TOTW   = 24;
    localparam int SYMW   = 5;
    localparam int FUNCW  = 2;

    localparam logic [FUNCW-1:0] F_APPEND = 2'd0;
    localparam logic [FUNCW-1:0] F_QUERY  = 2'd1;
    localparam logic [FUNCW-1:0] F_CLEAR  = 2'd2;

    typedef struct packed {
        logic [LW-1:0] len;
        logic [SW-1:0] link;
        logic [LW-1:0] cnt;
    } t_sent;

    typedef struct packed {
        logic [EW-1:0] tag;
        logic [SW-1:0] tgt;
    } t_tent;

    localparam int SWW = $bits(t_sent);
    localparam int TWW = $bits(t_tent);

    function automatic logic [TAW-1:0] row_base(input logic [SW-1:0] s);
        row_base = TAW'(s) * TAW'(ALPHABET);
    endfunction

endpackage

@@ rtl/odsc_ram.sv @@
// ----------------------------------------------------------------------------
// odsc_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module odsc_ram #(
    parameter int P_WIDTH = 8,
    parameter int P_DEPTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(P_DEPTH)-1:0] i_waddr,
    input  logic [P_WIDTH-1:0]         i_wdata,
    input  logic [$clog2(P_DEPTH)-1:0] i_raddr,
    output logic [P_WIDTH-1:0]         o_rdata
);

    logic [P_WIDTH-1:0] r_mem [P_DEPTH];
    logic [P_WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/online_distinct_substring_counter.sv @@
// ----------------------------------------------------------------------------
// online_distinct_substring_counter
// Suffix automaton built one symbol per append item, with a running count of
// distinct substrings. State table and transition table live in RAMs.
// ----------------------------------------------------------------------------
// query: result registered in the cycle after the item is taken; clear:
// root entry rewritten. append: a state and transition read per state visited
//   on the link walk plus a writeback, and a read of q when a transition
//   exists; a clone adds a row copy, two writebacks and a state and transition
//   read per link visited; throughput is set by each RAM's single read port
// reset and every 255th clear sweep the transition RAM, and no item is taken
//   meanwhile; other clears retire stale rows by an epoch tag
module online_distinct_substring_counter
    import odsc_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [4:0] symbol, rest zero
    input  logic [1:0]   s_axis_tuser,   // [1:0] func
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [23:0]  m_axis_tdata,   // [23:0] distinct_count
    output logic [0:0]   m_axis_tuser    // [0] capacity_full
);

    typedef enum logic [12:0] {
        S_SWEEP = 13'b0000000000001,
        S_ROOT  = 13'b0000000000010,
        S_IDLE  = 13'b0000000000100,
        S_W1    = 13'b0000000001000,
        S_W2    = 13'b0000000010000,
        S_Q1    = 13'b0000000100000,
        S_Q2    = 13'b0000001000000,
        S_CP    = 13'b0000010000000,
        S_C1    = 13'b0000100000000,
        S_C2    = 13'b0001000000000,
        S_FQ    = 13'b0010000000000,
        S_FCL   = 13'b0100000000000,
        S_FCUR  = 13'b1000000000000
    } t_state;

    t_state           r_state, n_state;
    logic [EW-1:0]    r_epoch, n_epoch;
    logic [TAW-1:0]   r_sweep, n_sweep;
    logic [SW-1:0]    r_last, n_last;
    logic [LW-1:0]    r_last_len, n_last_len;
    logic [NFW-1:0]   r_next_free, n_next_free;
    logic [TOTW-1:0]  r_total, n_total;
    logic             r_full, n_full;
    logic [SW-1:0]    r_cur, n_cur;
    logic [SYMW-1:0]  r_c, n_c;
    logic [SW-1:0]    r_p, n_p;
    logic [SW-1:0]    r_q, n_q;
    logic [SW-1:0]    r_cl, n_cl;
    logic [LW-1:0]    r_cur_cnt, n_cur_cnt;
    logic [SW-1:0]    r_cur_link, n_cur_link;
    logic [LW-1:0]    r_len_p, n_len_p;
    logic [LW-1:0]    r_q_len, n_q_len;
    logic [SW-1:0]    r_q_link, n_q_link;
    logic [LW-1:0]    r_q_cnt, n_q_cnt;
    logic [LW-1:0]    r_cl_cnt, n_cl_cnt;
    logic [LW-1:0]    r_cl_len, n_cl_len;
    logic [KW-1:0]    r_k, n_k;
    logic [KW-1:0]    r_k_d, n_k_d;
    logic             r_cp_pend, n_cp_pend;
    logic [TAW-1:0]   r_q_base, n_q_base;
    logic [TAW-1:0]   r_cl_base, n_cl_base;
    logic             r_out_valid, n_out_valid;
    logic [TOTW-1:0]  r_out_count, n_out_count;
    logic             r_out_full, n_out_full;

    logic             s_we;
    logic [SW-1:0]    s_waddr, s_raddr;
    t_sent            s_wdata, s_rdata;
    logic             t_we;
    logic [TAW-1:0]   t_waddr, t_raddr;
    t_tent            t_wdata, t_rdata;

    logic             in_acc;
    logic [FUNCW-1:0] in_func;
    logic [SYMW-1:0]  in_sym;
    logic [TAW-1:0]   p_addr;
    logic             t_hit;
    logic [TOTW:0]    sum_total;

    odsc_ram #(.P_WIDTH(SWW), .P_DEPTH(NSTATE)) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata),
        .i_raddr (s_raddr),
        .o_rdata (s_rdata)
    );

    odsc_ram #(.P_WIDTH(TWW), .P_DEPTH(TDEPTH)) u_trans_ram (
        .i_clk   (i_clk),
        .i_we    (t_we),
        .i_waddr (t_waddr),
        .i_wdata (t_wdata),
        .i_raddr (t_raddr),
        .o_rdata (t_rdata)
    );

    assign s_axis_tready = (r_state == S_IDLE) && (!r_out_valid || m_axis_tready);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign in_func       = s_axis_tuser;
    assign in_sym        = s_axis_tdata[SYMW-1:0];
    assign p_addr        = row_base(r_p) + TAW'(r_c);
    assign t_hit         = (t_rdata.tag == r_epoch);
    assign sum_total     = {1'b0, r_total} + (TOTW+1)'(s_rdata.cnt);

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_count;
    assign m_axis_tuser  = r_out_full;

    always_comb begin
        n_state     = r_state;
        n_epoch     = r_epoch;
        n_sweep     = r_sweep;
        n_last      = r_last;
        n_last_len  = r_last_len;
        n_next_free = r_next_free;
        n_total     = r_total;
        n_full      = r_full;
        n_cur       = r_cur;
        n_c         = r_c;
        n_p         = r_p;
        n_q         = r_q;
        n_cl        = r_cl;
        n_cur_cnt   = r_cur_cnt;
        n_cur_link  = r_cur_link;
        n_len_p     = r_len_p;
        n_q_len     = r_q_len;
        n_q_link    = r_q_link;
        n_q_cnt     = r_q_cnt;
        n_cl_cnt    = r_cl_cnt;
        n_cl_len    = r_cl_len;
        n_k         = r_k;
        n_k_d       = r_k_d;
        n_cp_pend   = r_cp_pend;
        n_q_base    = r_q_base;
        n_cl_base   = r_cl_base;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_count = r_out_count;
        n_out_full  = r_out_full;

        s_we    = 1'b0;
        s_waddr = '0;
        s_wdata = '0;
        s_raddr = '0;
        t_we    = 1'b0;
        t_waddr = '0;
        t_wdata = '0;
        t_raddr = '0;

        unique case (r_state)
            S_SWEEP: begin
                t_we    = 1'b1;
                t_waddr = r_sweep;
                if (r_sweep == TAW'(TDEPTH - 1)) begin
                    n_state = S_ROOT;
                end else begin
                    n_sweep = r_sweep + 1'b1;
                end
            end
            S_ROOT: begin
                s_we        = 1'b1;
                s_wdata.cnt = LW'(1);
                n_state     = S_IDLE;
            end
            S_IDLE: begin
                if (in_acc) begin
                    case (in_func)
                        F_APPEND: begin
                            if (in_sym < SYMW'(ALPHABET)) begin
                                if (r_last_len >= LW'(MAX_LEN) ||
                                    (NFW+1)'(r_next_free) + (NFW+1)'(2) >
                                    (NFW+1)'(NSTATE)) begin
                                    n_full = 1'b1;
                                end else begin
                                    n_cur       = r_next_free[SW-1:0];
                                    n_next_free = r_next_free + 1'b1;
                                    n_c         = in_sym;
                                    n_p         = r_last;
                                    n_cur_cnt   = '0;
                                    n_state     = S_W1;
                                end
                            end
                        end
                        F_QUERY: begin
                            n_out_valid = 1'b1;
                            n_out_count = r_total;
                            n_out_full  = r_full;
                        end
                        F_CLEAR: begin
                            n_last      = '0;
                            n_last_len  = '0;
                            n_next_free = NFW'(1);
                            n_total     = '0;
                            n_full      = 1'b0;
                            if (r_epoch == '1) begin
                                n_epoch = EW'(1);
                                n_sweep = '0;
                                n_state = S_SWEEP;
                            end else begin
                                n_epoch = r_epoch + 1'b1;
                                n_state = S_ROOT;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_W1, S_C1: begin
                s_raddr = r_p;
                t_raddr = p_addr;
                n_state = (r_state == S_W1) ? S_W2 : S_C2;
            end
            S_W2: begin
                if (t_hit) begin
                    n_q     = t_rdata.tgt;
                    n_len_p = s_rdata.len;
                    n_state = S_Q1;
                end else begin
                    t_we        = 1'b1;
                    t_waddr     = p_addr;
                    t_wdata.tag = r_epoch;
                    t_wdata.tgt = r_cur;
                    n_cur_cnt   = r_cur_cnt + s_rdata.cnt;
                    n_total     = sum_total[TOTW] ? '1 : sum_total[TOTW-1:0];
                    if (r_p == '0) begin
                        n_cur_link = '0;
                        n_state    = S_FCUR;
                    end else begin
                        n_p     = s_rdata.link;
                        n_state = S_W1;
                    end
                end
            end
            S_Q1: begin
                s_raddr = r_q;
                n_state = S_Q2;
            end
            S_Q2: begin
                if (r_len_p + 1'b1 == s_rdata.len) begin
                    n_cur_link = r_q;
                    n_state    = S_FCUR;
                end else begin
                    n_cl        = r_next_free[SW-1:0];
                    n_next_free = r_next_free + 1'b1;
                    n_q_len     = s_rdata.len;
                    n_q_link    = s_rdata.link;
                    n_q_cnt     = s_rdata.cnt;
                    n_cl_cnt    = '0;
                    n_cl_len    = r_len_p + 1'b1;
                    n_cur_link  = r_next_free[SW-1:0];
                    n_q_base    = row_base(r_q);
                    n_cl_base   = row_base(r_next_free[SW-1:0]);
                    n_k         = '0;
                    n_cp_pend   = 1'b0;
                    n_state     = S_CP;
                end
            end
            S_CP: begin
                // read q row entry k, write the previous one into the clone row
                if (r_cp_pend) begin
                    t_we    = 1'b1;
                    t_waddr = r_cl_base + TAW'(r_k_d);
                    t_wdata = t_rdata;
                end
                if (r_k < KW'(ALPHABET)) begin
                    t_raddr   = r_q_base + TAW'(r_k);
                    n_k       = r_k + 1'b1;
                    n_k_d     = r_k;
                    n_cp_pend = 1'b1;
                end else begin
                    n_cp_pend = 1'b0;
                    n_state   = S_C1;
                end
            end
            S_C2: begin
                if (t_hit && t_rdata.tgt == r_q) begin
                    t_we        = 1'b1;
                    t_waddr     = p_addr;
                    t_wdata.tag = r_epoch;
                    t_wdata.tgt = r_cl;
                    n_q_cnt     = r_q_cnt - s_rdata.cnt;
                    n_cl_cnt    = r_cl_cnt + s_rdata.cnt;
                    if (r_p == '0) begin
                        n_state = S_FQ;
                    end else begin
                        n_p     = s_rdata.link;
                        n_state = S_C1;
                    end
                end else begin
                    n_state = S_FQ;
                end
            end
            S_FQ: begin
                s_we         = 1'b1;
                s_waddr      = r_q;
                s_wdata.len  = r_q_len;
                s_wdata.link = r_cl;
                s_wdata.cnt  = r_q_cnt;
                n_state      = S_FCL;
            end
            S_FCL: begin
                s_we         = 1'b1;
                s_waddr      = r_cl;
                s_wdata.len  = r_cl_len;
                s_wdata.link = r_q_link;
                s_wdata.cnt  = r_cl_cnt;
                n_state      = S_FCUR;
            end
            S_FCUR: begin
                s_we         = 1'b1;
                s_waddr      = r_cur;
                s_wdata.len  = r_last_len + 1'b1;
                s_wdata.link = r_cur_link;
                s_wdata.cnt  = r_cur_cnt;
                n_last       = r_cur;
                n_last_len   = r_last_len + 1'b1;
                n_state      = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_SWEEP;
            r_epoch     <= EW'(1);
            r_sweep     <= '0;
            r_last      <= '0;
            r_last_len  <= '0;
            r_next_free <= NFW'(1);
            r_total     <= '0;
            r_full      <= 1'b0;
            r_cp_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_epoch     <= n_epoch;
            r_sweep     <= n_sweep;
            r_last      <= n_last;
            r_last_len  <= n_last_len;
            r_next_free <= n_next_free;
            r_total     <= n_total;
            r_full      <= n_full;
            r_cp_pend   <= n_cp_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur       <= n_cur;
        r_c         <= n_c;
        r_p         <= n_p;
        r_q         <= n_q;
        r_cl        <= n_cl;
        r_cur_cnt   <= n_cur_cnt;
        r_cur_link  <= n_cur_link;
        r_len_p     <= n_len_p;
        r_q_len     <= n_q_len;
        r_q_link    <= n_q_link;
        r_q_cnt     <= n_q_cnt;
        r_cl_cnt    <= n_cl_cnt;
        r_cl_len    <= n_cl_len;
        r_k         <= n_k;
        r_k_d       <= n_k_d;
        r_q_base    <= n_q_base;
        r_cl_base   <= n_cl_base;
        r_out_count <= n_out_count;
        r_out_full  <= n_out_full;
    end

    a_query_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && in_func == F_QUERY) |=> m_axis_tvalid)
        else $error("query item gave no result");

    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next_free <= NFW'(NSTATE))
        else $error("state allocation past capacity");

    a_sweep_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP) |-> !s_axis_tready)
        else $error("item taken during table sweep");

    a_total_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$past(in_acc && in_func == F_CLEAR))
            |-> r_total >= $past(r_total))
        else $error("distinct total shrank without clear");

endmodule

@@ dv/online_distinct_substring_counter_tb.sv @@
// ----------------------------------------------------------------------------
// online_distinct_substring_counter_tb
// Streams append, query, clear and ignored items into the counter. A local
// suffix automaton predicts each query result. Both stream sides idle and
// stall at random. A long receiver hold fills the block and stalls its input.
// ----------------------------------------------------------------------------
module online_distinct_substring_counter_tb;
    import odsc_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000000;

    typedef struct packed {
        logic [FUNCW-1:0] func;
        logic [SYMW-1:0]  sym;
    } t_req;

    typedef struct packed {
        logic [23:0] count;
        logic        full;
    } t_answer;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata;   // [4:0] symbol, rest zero
    logic [1:0]   s_axis_tuser;   // [1:0] func
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [23:0]  m_axis_tdata;   // [23:0] distinct_count
    logic [0:0]   m_axis_tuser;   // [0] capacity_full

    online_distinct_substring_counter u_dut (.*);

    // suffix automaton kept by the bench
    int unsigned sa_len  [NSTATE];
    int unsigned sa_link [NSTATE];
    int unsigned sa_paths[NSTATE];
    int unsigned sa_next [NSTATE*ALPHABET];
    bit          sa_has  [NSTATE*ALPHABET];
    int unsigned sa_last, sa_free;
    longint unsigned substr_total;
    bit          sa_full;

    t_req    pending_items[$];
    t_answer expected_answers[$];
    int      errors;
    int      send_idle_pct, recv_stall_pct;
    int      hold_cycles;
    bit      in_taken;
    int      quiet_cycles;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic void sa_clear();
        sa_last = 0;
        sa_free = 1;
        sa_len[0] = 0;
        sa_link[0] = 0;
        sa_paths[0] = 1;
        for (int a = 0; a < ALPHABET; a++) sa_has[a] = 0;
        substr_total = 0;
        sa_full = 0;
    endfunction

    function automatic void sa_extend(int unsigned c);
        int unsigned cur, p, q, cl;
        bit found;
        found = 0;
        if (sa_len[sa_last] >= MAX_LEN || sa_free + 2 > NSTATE) begin
            sa_full = 1;
            return;
        end
        cur = sa_free++;
        sa_len[cur] = sa_len[sa_last] + 1;
        for (int a = 0; a < ALPHABET; a++) sa_has[cur*ALPHABET+a] = 0;
        sa_paths[cur] = 0;
        p = sa_last;
        forever begin
            if (sa_has[p*ALPHABET+c]) begin
                found = 1;
                break;
            end
            sa_has[p*ALPHABET+c] = 1;
            sa_next[p*ALPHABET+c] = cur;
            sa_paths[cur] += sa_paths[p];
            substr_total += sa_paths[p];
            if (p == 0) break;
            p = sa_link[p];
        end
        if (!found) begin
            sa_link[cur] = 0;
        end else begin
            q = sa_next[p*ALPHABET+c];
            if (sa_len[p] + 1 == sa_len[q]) begin
                sa_link[cur] = q;
            end else begin
                cl = sa_free++;
                sa_len[cl] = sa_len[p] + 1;
                for (int a = 0; a < ALPHABET; a++) begin
                    sa_has[cl*ALPHABET+a]  = sa_has[q*ALPHABET+a];
                    sa_next[cl*ALPHABET+a] = sa_next[q*ALPHABET+a];
                end
                sa_paths[cl] = 0;
                sa_link[cl] = sa_link[q];
                forever begin
                    if (!sa_has[p*ALPHABET+c] || sa_next[p*ALPHABET+c] != q) break;
                    sa_next[p*ALPHABET+c] = cl;
                    sa_paths[q] -= sa_paths[p];
                    sa_paths[cl] += sa_paths[p];
                    if (p == 0) break;
                    p = sa_link[p];
                end
                sa_link[q] = cl;
                sa_link[cur] = cl;
            end
        end
        sa_last = cur;
    endfunction

    function automatic void predict_item(t_req r);
        t_answer ans;
        if (r.func == F_APPEND) begin
            if (r.sym < ALPHABET) sa_extend(r.sym);
        end else if (r.func == F_QUERY) begin
            ans.count = (substr_total > 64'hFFFFFF) ? 24'hFFFFFF : substr_total[23:0];
            ans.full  = sa_full;
            expected_answers.push_back(ans);
        end else if (r.func == F_CLEAR) begin
            sa_clear();
        end
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $time);
        errors++;
    endtask

    task automatic push_item(logic [FUNCW-1:0] f, logic [SYMW-1:0] s);
        t_req r;
        r.func = f;
        r.sym  = s;
        pending_items.push_back(r);
    endtask

    // appends mostly over alpha symbols, queries, clears and ignored items
    task automatic push_random(int n, int alpha);
        int k;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(99);
            if (k < 70)      push_item(F_APPEND, SYMW'($urandom_range(alpha - 1)));
            else if (k < 76) push_item(F_APPEND, SYMW'($urandom_range(ALPHABET - 1)));
            else if (k < 92) push_item(F_QUERY, SYMW'($urandom_range(31)));
            else if (k < 94) push_item(F_CLEAR, SYMW'($urandom_range(31)));
            else if (k < 97) push_item(F_APPEND, SYMW'($urandom_range(31, ALPHABET)));
            else             push_item(2'd3, SYMW'($urandom_range(31)));
        end
    endtask

    task automatic drain();
        wait (pending_items.size() == 0 && !s_axis_tvalid);
        wait (expected_answers.size() == 0);
    endtask

    // sender
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_taken) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                t_req r;
                r = pending_items.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= r.func;
                s_axis_tdata  <= {3'b000, r.sym};
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver, with a counted long hold-off
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_req    r;
        t_answer want;
        in_taken <= s_axis_tvalid && s_axis_tready;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            r.func = s_axis_tuser;
            r.sym  = s_axis_tdata[4:0];
            predict_item(r);
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_answers.size() == 0) begin
                report_mismatch("unexpected result item, distinct_count", m_axis_tdata, 0);
            end else begin
                want = expected_answers.pop_front();
                if (m_axis_tdata != want.count)
                    report_mismatch("distinct_count", m_axis_tdata, want.count);
                if (m_axis_tuser[0] != want.full)
                    report_mismatch("capacity_full", m_axis_tuser[0], want.full);
            end
        end
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("** online_distinct_substring_counter: FAILED **");
            $finish;
        end
    end

    initial begin
        errors = 0;
        quiet_cycles = 0;
        in_taken = 0;
        hold_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        m_axis_tready = 0;
        sa_clear();
        i_rst_n = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;

        // directed: empty text, symbol extremes, ignored items, repeats
        push_item(F_QUERY, 5'd0);
        push_item(F_APPEND, 5'd0);
        push_item(F_APPEND, 5'd25);
        push_item(F_QUERY, 5'd31);
        push_item(F_APPEND, 5'd26);
        push_item(F_APPEND, 5'd31);
        push_item(2'd3, 5'd31);
        push_item(F_QUERY, 5'd0);
        push_item(F_CLEAR, 5'd0);
        push_item(F_QUERY, 5'd0);
        repeat (4) push_item(F_APPEND, 5'd1);
        push_item(F_QUERY, 5'd0);
        push_item(F_APPEND, 5'd0);
        push_item(F_APPEND, 5'd1);
        push_item(F_APPEND, 5'd0);
        push_item(F_APPEND, 5'd1);
        push_item(F_APPEND, 5'd16);
        push_item(F_QUERY, 5'd0);
        push_item(F_CLEAR, 5'd31);
        push_item(F_QUERY, 5'd0);
        push_random(330, 3);
        drain();

        send_idle_pct = 46;
        push_random(300, 2);
        drain();
        send_idle_pct = 0;
        recv_stall_pct = 46;
        push_random(300, 4);
        drain();
        send_idle_pct = 10;
        recv_stall_pct = 10;
        push_random(300, 26);
        drain();

        // long receiver hold while appends and queries keep coming
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 3000;
        push_random(300, 3);
        drain();

        repeat (100) @(posedge i_clk);
        if (errors == 0)
            $display("** online_distinct_substring_counter: PASSED **");
        else
            $display("** online_distinct_substring_counter: FAILED **");
        $finish;
    end

endmodule
